// ===== hw/rtl/angle_rate_accel_estimator_macros.svh =====
// Assertion macros shared by the estimator RTL.
// Depends on nothing; files that assert include it by name.
`ifndef ANGLE_RATE_ACCEL_ESTIMATOR_MACROS_SVH
`define ANGLE_RATE_ACCEL_ESTIMATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ARAE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ARAE_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define ARAE_ASSERT(lbl, prop, msg)
`define ARAE_IMPLY(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/arae_pkg.sv =====
// Shared constants, types and the angle wrap function of the estimator.
// Depends on nothing.
package arae_pkg;
  localparam int ANGLE_FRAC_BITS = 16;
  localparam longint unsigned PI_Q60 = 64'h3243F6A8885A308D;
  localparam longint unsigned PI_FIX =
    (PI_Q60 + (64'd1 << (59 - ANGLE_FRAC_BITS))) >> (60 - ANGLE_FRAC_BITS);

  localparam int STAMP_W = 48;
  localparam int ANGLE_W = 19;
  localparam int DIFF_W  = 20;
  localparam int RATE_W  = 22;
  localparam int ACC_W   = 26;
  localparam int DT_W    = 20;
  localparam int LIM_W   = 25;
  localparam int VAL_W   = 24;
  localparam int NUM_W   = 44;
  localparam int CFG_W   = 25;
  localparam int IDX_W   = 3;
  localparam logic [DT_W-1:0] US_PER_S = 20'd1000000;

  localparam logic [IDX_W-1:0] REG_MIN_DT  = 3'd0;
  localparam logic [IDX_W-1:0] REG_MAX_DT  = 3'd1;
  localparam logic [IDX_W-1:0] REG_DEF_DT  = 3'd2;
  localparam logic [IDX_W-1:0] REG_RATE_LM = 3'd3;
  localparam logic [IDX_W-1:0] REG_ACC_LM  = 3'd4;

  localparam logic signed [DIFF_W-1:0] PI_D   = DIFF_W'(PI_FIX);
  localparam logic signed [DIFF_W-1:0] TWO_PI = DIFF_W'(2 * PI_FIX);

  typedef struct packed {
    logic                    start;
    logic signed [VAL_W-1:0] value;
    logic [LIM_W-1:0]        limit;
    logic [DT_W-1:0]         dt;
  } lane_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [ACC_W-1:0] result;
  } lane_rsp_t;

  // One correction step covers every difference of two 19-bit angles.
  function automatic logic signed [DIFF_W-1:0] wrap_diff(input logic signed [DIFF_W-1:0] d);
    logic signed [DIFF_W-1:0] w;
    w = d;
    if (d > PI_D) w = d - TWO_PI;
    else if (d < -PI_D) w = d + TWO_PI;
    return w;
  endfunction
endpackage

// ===== hw/rtl/arae_lane.sv =====
// One derivative lane: scales a difference by 1e6, divides by the interval
// with a restoring bit-serial divider, then clamps. Depends on arae_pkg.
module arae_lane import arae_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  lane_req_t req,
  output lane_rsp_t rsp
);
  localparam int CNT_W = $clog2(NUM_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] quo_r;
  logic [DT_W-1:0]  rem_r;
  logic [DT_W-1:0]  dt_r;
  logic [LIM_W-1:0] lim_r;
  logic             neg_r;

  logic [VAL_W-1:0] mag;
  logic [DT_W:0]    rem_sh;
  logic             ge;
  logic [DT_W:0]    rem_nxt;
  logic [LIM_W-1:0] clamped;

  assign mag     = req.value[VAL_W-1] ? VAL_W'(-req.value) : VAL_W'(req.value);
  assign rem_sh  = {rem_r, quo_r[NUM_W-1]};
  assign ge      = rem_sh >= {1'b0, dt_r};
  assign rem_nxt = ge ? (rem_sh - {1'b0, dt_r}) : rem_sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NUM_W - 1)) busy_r <= 1'b0;
      end
      done_r <= busy_r && !req.start && (cnt_r == CNT_W'(NUM_W - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= NUM_W'(mag) * NUM_W'(US_PER_S);
      rem_r <= '0;
      dt_r  <= req.dt;
      lim_r <= req.limit;
      neg_r <= req.value[VAL_W-1];
    end else if (busy_r) begin
      rem_r <= rem_nxt[DT_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], ge};
    end
  end

  assign clamped = (quo_r > NUM_W'(lim_r)) ? lim_r : quo_r[LIM_W-1:0];
  assign rsp.done   = done_r;
  assign rsp.result = neg_r ? -$signed({1'b0, clamped}) : $signed({1'b0, clamped});
endmodule

// ===== hw/rtl/angle_rate_accel_estimator.sv =====
// Yaw and pitch rate and acceleration estimator. An item passes from ST_IDLE through ST_CALC,
// then ST_RATE when rates count and ST_ACCEL when accelerations count, to ST_WRITE, which
// moves it into the output register; a new input is taken only back in ST_IDLE.
// Each derivative is one 44-step bit-serial division per lane, both lanes in parallel;
// a stalled result adds its stall. Synchronous active-low reset clears the history.
// Depends on arae_pkg, arae_lane and angle_rate_accel_estimator_macros.svh.
`include "angle_rate_accel_estimator_macros.svh"
module angle_rate_accel_estimator import arae_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [IDX_W-1:0]          cfg_idx,
  input  logic [CFG_W-1:0]          cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_control_on,
  input  logic                      in_fire_flag,
  input  logic [STAMP_W-1:0]        in_frame_time_us,
  input  logic signed [ANGLE_W-1:0] in_yaw_cmd,
  input  logic signed [ANGLE_W-1:0] in_pitch_cmd,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_control_out,
  output logic                      out_fire_out,
  output logic [STAMP_W-1:0]        out_stamp_out,
  output logic signed [ANGLE_W-1:0] out_yaw_out,
  output logic signed [ANGLE_W-1:0] out_pitch_out,
  output logic signed [RATE_W-1:0]  out_yaw_rate,
  output logic signed [RATE_W-1:0]  out_pitch_rate,
  output logic signed [ACC_W-1:0]   out_yaw_accel,
  output logic signed [ACC_W-1:0]   out_pitch_accel
);
  typedef enum logic [2:0] {ST_IDLE, ST_CALC, ST_RATE, ST_ACCEL, ST_WRITE} state_t;
  state_t state_r;

  // Configuration registers.
  logic [DT_W-1:0]    min_dt_r, max_dt_r, def_dt_r;
  logic [RATE_W-2:0]  rate_lim_r;
  logic [LIM_W-1:0]   acc_lim_r;

  // History carried from one counted item to the next.
  logic                      have_cmd_r, have_rate_r;
  logic [STAMP_W-1:0]        prior_stamp_r;
  logic signed [ANGLE_W-1:0] prior_yaw_r, prior_pitch_r;
  logic signed [RATE_W-1:0]  prior_yrate_r, prior_prate_r;

  // The item in work.
  logic                      ctrl_r, fire_r, valid_r;
  logic [STAMP_W-1:0]        stamp_r;
  logic signed [ANGLE_W-1:0] yaw_r, pitch_r;
  logic signed [RATE_W-1:0]  yrate_r, prate_r;
  logic signed [ACC_W-1:0]   yacc_r, pacc_r;
  logic [DT_W-1:0]           dt_r;

  // Output register.
  logic                      out_valid_r, oc_r, of_r;
  logic [STAMP_W-1:0]        os_r;
  logic signed [ANGLE_W-1:0] oy_r, op_r;
  logic signed [RATE_W-1:0]  oyr_r, opr_r;
  logic signed [ACC_W-1:0]   oya_r, opa_r;

  lane_req_t yreq_r, preq_r;
  lane_rsp_t yrsp, prsp;

  // Interval choice and its bounds check for the item in work.
  logic [STAMP_W-1:0]       dt_full;
  logic                     dt_ok;
  logic signed [DIFF_W-1:0] ydiff, pdiff;
  logic signed [RATE_W-1:0] yrate_new, prate_new;

  // Handshake and lane start decisions for this cycle.
  logic                     write_go;
  logic                     out_valid_nxt;
  logic                     lane_go_nxt;

  assign dt_full = (stamp_r > prior_stamp_r && prior_stamp_r != '0) ?
                   (stamp_r - prior_stamp_r) : STAMP_W'(def_dt_r);
  assign dt_ok   = dt_full != '0 && dt_full >= STAMP_W'(min_dt_r) &&
                   dt_full <= STAMP_W'(max_dt_r);
  assign ydiff   = wrap_diff(DIFF_W'(yaw_r) - DIFF_W'(prior_yaw_r));
  assign pdiff   = wrap_diff(DIFF_W'(pitch_r) - DIFF_W'(prior_pitch_r));
  assign yrate_new = yrsp.result[RATE_W-1:0];
  assign prate_new = prsp.result[RATE_W-1:0];

  // The finished item moves into the output register once that register is
  // empty or its result transfer happens in the same cycle.
  assign write_go      = (state_r == ST_WRITE) && (!out_valid_r || !out_stall);
  assign out_valid_nxt = write_go || (out_valid_r && out_stall);

  // Both lanes start together: rates after the interval check, accelerations
  // once the rates are in and a prior rate exists.
  assign lane_go_nxt = (state_r == ST_CALC && ctrl_r && have_cmd_r && dt_ok) ||
                       (state_r == ST_RATE && yrsp.done && have_rate_r);

  assign in_stall = state_r != ST_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_dt_r   <= 20'd1000;
      max_dt_r   <= 20'd200000;
      def_dt_r   <= 20'd10000;
      rate_lim_r <= 21'd1966080;
      acc_lim_r  <= 25'd19660800;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_MIN_DT:  min_dt_r   <= cfg_wdata[DT_W-1:0];
        REG_MAX_DT:  max_dt_r   <= cfg_wdata[DT_W-1:0];
        REG_DEF_DT:  def_dt_r   <= cfg_wdata[DT_W-1:0];
        REG_RATE_LM: rate_lim_r <= cfg_wdata[RATE_W-2:0];
        REG_ACC_LM:  acc_lim_r  <= cfg_wdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      have_cmd_r    <= 1'b0;
      have_rate_r   <= 1'b0;
      prior_stamp_r <= '0;
      prior_yaw_r   <= '0;
      prior_pitch_r <= '0;
      prior_yrate_r <= '0;
      prior_prate_r <= '0;
      yreq_r.start  <= 1'b0;
      preq_r.start  <= 1'b0;
    end else begin
      yreq_r.start <= lane_go_nxt;
      preq_r.start <= lane_go_nxt;
      out_valid_r  <= out_valid_nxt;
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            ctrl_r  <= in_control_on;
            fire_r  <= in_fire_flag;
            stamp_r <= in_frame_time_us;
            yaw_r   <= in_yaw_cmd;
            pitch_r <= in_pitch_cmd;
            state_r <= ST_CALC;
          end
        end
        ST_CALC: begin
          yrate_r <= '0;
          prate_r <= '0;
          yacc_r  <= '0;
          pacc_r  <= '0;
          valid_r <= ctrl_r && have_cmd_r && dt_ok;
          dt_r    <= dt_full[DT_W-1:0];
          if (ctrl_r && have_cmd_r && dt_ok) begin
            yreq_r.value <= VAL_W'(ydiff);
            yreq_r.limit <= LIM_W'(rate_lim_r);
            yreq_r.dt    <= dt_full[DT_W-1:0];
            preq_r.value <= VAL_W'(pdiff);
            preq_r.limit <= LIM_W'(rate_lim_r);
            preq_r.dt    <= dt_full[DT_W-1:0];
            state_r <= ST_RATE;
          end else begin
            state_r <= ST_WRITE;
          end
        end
        ST_RATE: begin
          if (yrsp.done) begin
            yrate_r <= yrate_new;
            prate_r <= prate_new;
            if (have_rate_r) begin
              // Difference of clamped rates feeds the second division.
              yreq_r.value <= VAL_W'(yrate_new) - VAL_W'(prior_yrate_r);
              yreq_r.limit <= acc_lim_r;
              yreq_r.dt    <= dt_r;
              preq_r.value <= VAL_W'(prate_new) - VAL_W'(prior_prate_r);
              preq_r.limit <= acc_lim_r;
              preq_r.dt    <= dt_r;
              state_r <= ST_ACCEL;
            end else begin
              state_r <= ST_WRITE;
            end
          end
        end
        ST_ACCEL: begin
          if (yrsp.done) begin
            yacc_r  <= yrsp.result;
            pacc_r  <= prsp.result;
            state_r <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          if (write_go) begin
            oc_r  <= ctrl_r;
            of_r  <= fire_r;
            os_r  <= stamp_r;
            oy_r  <= ctrl_r ? yaw_r : '0;
            op_r  <= ctrl_r ? pitch_r : '0;
            oyr_r <= yrate_r;
            opr_r <= prate_r;
            oya_r <= yacc_r;
            opa_r <= pacc_r;
            // Control off wipes the history; otherwise this item becomes it.
            have_cmd_r    <= ctrl_r;
            have_rate_r   <= valid_r;
            prior_stamp_r <= ctrl_r ? stamp_r : '0;
            prior_yaw_r   <= ctrl_r ? yaw_r : '0;
            prior_pitch_r <= ctrl_r ? pitch_r : '0;
            prior_yrate_r <= yrate_r;
            prior_prate_r <= prate_r;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  arae_lane u_yaw_lane (.clk(clk), .rst_n(rst_n), .req(yreq_r), .rsp(yrsp));
  arae_lane u_pitch_lane (.clk(clk), .rst_n(rst_n), .req(preq_r), .rsp(prsp));

  assign out_valid       = out_valid_r;
  assign out_control_out = oc_r;
  assign out_fire_out    = of_r;
  assign out_stamp_out   = os_r;
  assign out_yaw_out     = oy_r;
  assign out_pitch_out   = op_r;
  assign out_yaw_rate    = oyr_r;
  assign out_pitch_rate  = opr_r;
  assign out_yaw_accel   = oya_r;
  assign out_pitch_accel = opa_r;

  `ARAE_ASSERT(a_lanes_lockstep, yrsp.done == prsp.done, "lanes finished apart")
  `ARAE_IMPLY(a_out_from_write, $rose(out_valid_r), $past(state_r == ST_WRITE), "stray result")
  `ARAE_IMPLY(a_rate_needs_cmd, have_rate_r, have_cmd_r, "prior rate without prior command")
endmodule
